FILE: rtl/oiwf_pkg.sv
package oiwf_pkg;

    localparam logic [7:0] RESET_ADDRESS_BYTE = 8'h78;
    localparam logic [7:0] CTRL_COMMAND       = 8'h00;
    localparam logic [7:0] CTRL_DATA          = 8'h40;

    localparam logic [1:0] SYM_START = 2'd0;
    localparam logic [1:0] SYM_BIT   = 2'd1;
    localparam logic [1:0] SYM_ACK   = 2'd2;
    localparam logic [1:0] SYM_STOP  = 2'd3;

    localparam int BYTE_BITS   = 8;
    localparam int FRAME_BYTES = 3;
    localparam int FRAME_BITS  = BYTE_BITS * FRAME_BYTES;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       mode;
        logic [7:0] payload;
    } in_t;

    typedef struct packed {
        logic [1:0] symbol;
        logic       sda_level;
        logic       last;
    } out_t;

    typedef logic [FRAME_BITS-1:0] frame_t;

    typedef struct packed {
        logic   valid;
        frame_t frame;
    } head_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_BYTES,
        BK_STOP
    } back_state_t;

endpackage

FILE: rtl/oiwf_front.sv
module oiwf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    input  logic               push,
    input  oiwf_pkg::in_t      item,
    input  logic               queue_full,
    output logic               queue_wr,
    output oiwf_pkg::frame_t   queue_data
);

    logic [7:0] address_reg;
    logic [7:0] control;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg <= oiwf_pkg::RESET_ADDRESS_BYTE;
        end
        else if (cfg_we)
        begin
            address_reg <= cfg_data;
        end
    end

    always_comb
    begin
        control    = item.mode ? oiwf_pkg::CTRL_DATA : oiwf_pkg::CTRL_COMMAND;
        queue_wr   = push && !queue_full;
        queue_data = {address_reg, control, item.payload};
    end

endmodule

FILE: rtl/oiwf_queue.sv
module oiwf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  oiwf_pkg::frame_t   wr_data,
    output logic               full,
    input  logic               rd,
    output oiwf_pkg::head_t    head
);

    oiwf_pkg::frame_t                mem [oiwf_pkg::QUEUE_DEPTH];
    logic [oiwf_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [oiwf_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [oiwf_pkg::QUEUE_CW-1:0]   count_reg;
    logic                            do_rd;

    localparam logic [oiwf_pkg::QUEUE_AW-1:0] LAST_PTR =
        oiwf_pkg::QUEUE_AW'(oiwf_pkg::QUEUE_DEPTH - 1);
    localparam logic [oiwf_pkg::QUEUE_CW-1:0] DEPTH_CNT =
        oiwf_pkg::QUEUE_CW'(oiwf_pkg::QUEUE_DEPTH);

    assign full       = (count_reg == DEPTH_CNT);
    assign head.valid = (count_reg != '0);
    assign head.frame = mem[rd_ptr_reg];
    assign do_rd      = rd && head.valid;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!wr && do_rd)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/oiwf_back.sv
module oiwf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  oiwf_pkg::head_t    head,
    output logic               head_rd,
    input  logic               pop,
    output logic               empty,
    output oiwf_pkg::out_t     result
);

    oiwf_pkg::back_state_t state_reg, state_next;
    oiwf_pkg::frame_t      shift_reg, shift_next;
    logic [3:0]            bit_reg, bit_next;
    logic [1:0]            byte_reg, byte_next;
    logic                  lastbit_reg, lastbit_next;
    logic                  out_valid_reg, out_valid_next;
    oiwf_pkg::out_t        out_reg, out_next;
    logic                  can_emit;

    localparam logic [3:0] ACK_SLOT  = 4'(oiwf_pkg::BYTE_BITS);
    localparam logic [1:0] LAST_BYTE = 2'(oiwf_pkg::FRAME_BYTES - 1);

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oiwf_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        bit_reg     <= bit_next;
        byte_reg    <= byte_next;
        lastbit_reg <= lastbit_next;
        out_reg     <= out_next;
    end

    always_comb
    begin
        can_emit       = !out_valid_reg || pop;
        state_next     = state_reg;
        shift_next     = shift_reg;
        bit_next       = bit_reg;
        byte_next      = byte_reg;
        lastbit_next   = lastbit_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        head_rd        = 1'b0;
        case (state_reg)
            oiwf_pkg::BK_IDLE:
            begin
                if (can_emit && head.valid)
                begin
                    head_rd        = 1'b1;
                    shift_next     = head.frame;
                    bit_next       = '0;
                    byte_next      = '0;
                    out_next       = '{oiwf_pkg::SYM_START, 1'b0, 1'b0};
                    out_valid_next = 1'b1;
                    state_next     = oiwf_pkg::BK_BYTES;
                end
            end
            oiwf_pkg::BK_BYTES:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    if (bit_reg == ACK_SLOT)
                    begin
                        out_next = '{oiwf_pkg::SYM_ACK, lastbit_reg, 1'b0};
                        bit_next = '0;
                        if (byte_reg == LAST_BYTE)
                        begin
                            state_next = oiwf_pkg::BK_STOP;
                        end
                        else
                        begin
                            byte_next = byte_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        out_next     = '{oiwf_pkg::SYM_BIT,
                                         shift_reg[oiwf_pkg::FRAME_BITS-1], 1'b0};
                        lastbit_next = shift_reg[oiwf_pkg::FRAME_BITS-1];
                        shift_next   = {shift_reg[oiwf_pkg::FRAME_BITS-2:0], 1'b0};
                        bit_next     = bit_reg + 1'b1;
                    end
                end
            end
            oiwf_pkg::BK_STOP:
            begin
                if (can_emit)
                begin
                    out_next       = '{oiwf_pkg::SYM_STOP, 1'b0, 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = oiwf_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = oiwf_pkg::BK_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/oled_i2c_write_framer_core.sv
// channel   signals                 handshake
// request   item (mode, payload)    push / full
// result    result (symbol, sda,    empty / pop
//           last)
// config    cfg_data                cfg_we, no wait
//
// Each request expands to 29 bus symbols, one per cycle from the back-end
// sequencer while result pops keep up, so a request is taken per 29 symbols.
// Start of a queued transaction follows the stop of the previous one directly.
// A two-entry queue of built frames and the output register absorb stalls.
// Reset clears the queue, the sequencer and the address byte to 0x78.
module oled_i2c_write_framer_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data,
    input  logic              push,
    output logic              full,
    input  oiwf_pkg::in_t     item,
    input  logic              pop,
    output logic              empty,
    output oiwf_pkg::out_t    result
);

    logic              queue_wr;
    oiwf_pkg::frame_t  queue_data;
    logic              head_rd;
    oiwf_pkg::head_t   head;

    oiwf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .push       (push),
        .item       (item),
        .queue_full (full),
        .queue_wr   (queue_wr),
        .queue_data (queue_data)
    );

    oiwf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (queue_wr),
        .wr_data (queue_data),
        .full    (full),
        .rd      (head_rd),
        .head    (head)
    );

    oiwf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .head_rd (head_rd),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule
